### rtl/rsp_pkg.sv
// Shared types, constants and GF(256) helper functions for the RS parity generator.
package rsp_pkg;

  // Default and largest supported parity length in bytes
  localparam int ParityBytesDefault = 48;
  localparam int MaxParityBytes     = 64;

  // Field polynomial x^8+x^4+x^3+x^2+1: low part and the bit that folds back
  localparam logic [7:0] FieldLowPoly = 8'h1D;
  localparam logic [7:0] FieldTopBit  = 8'h80;

  // Per-cycle control broadcast from the top level to every cell
  typedef struct packed {
    logic       step;   // a data byte is accepted: advance the remainder
    logic       load;   // last data byte: move remainder to output row, clear
    logic       shift;  // output byte taken: advance the output row
    logic [7:0] fb;     // feedback byte of the division
  } rsp_ctrl_t;

  // Multiply two field elements (shift-and-add, reduced by the field polynomial)
  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] a;
    logic [7:0] acc;
    a   = x;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc = acc ^ a;
      end
      if ((a & FieldTopBit) != 8'h00) begin
        a = {a[6:0], 1'b0} ^ FieldLowPoly;
      end else begin
        a = {a[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // Coefficient k (leading term first) of the generator with roots alpha^0..alpha^(n-1)
  function automatic logic [7:0] gen_coef(input int n, input int k);
    logic [7:0] g [0:MaxParityBytes];
    logic [7:0] root;
    for (int i = 0; i <= MaxParityBytes; i++) begin
      g[i] = 8'h00;
    end
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j > 0; j--) begin
        g[j] = g[j] ^ gf_mul(g[j-1], root);
      end
      root = gf_mul(root, 8'h02);
    end
    return g[k];
  endfunction

endpackage

### rtl/rsp_cell.sv
// One stage of the division register plus its slot in the parity output row.
module rsp_cell #(
  parameter logic [7:0] COEF = 8'h01
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsp_pkg::rsp_ctrl_t ctrl_i,
  input  logic [7:0]        rem_up_i,   // remainder byte of the next higher cell
  input  logic [7:0]        par_up_i,   // output byte of the next higher cell
  output logic [7:0]        rem_o,
  output logic [7:0]        par_o
);
  import rsp_pkg::*;

  logic [7:0] rem_q, rem_d;
  logic [7:0] par_q, par_d;
  logic [7:0] rem_nxt;

  // Divide step: take the neighbor's byte and add the scaled feedback
  assign rem_nxt = rem_up_i ^ gf_mul(ctrl_i.fb, COEF);

  // Clear on the last byte, advance on every other accepted byte
  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.load) begin
      rem_d = 8'h00;
    end else if (ctrl_i.step) begin
      rem_d = rem_nxt;
    end
  end

  // Capture the finished remainder, or shift the output row toward the port
  always_comb begin
    par_d = par_q;
    if (ctrl_i.load) begin
      par_d = rem_nxt;
    end else if (ctrl_i.shift) begin
      par_d = par_up_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 8'h00;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 8'h00;
    end else begin
      par_q <= par_d;
    end
  end

  assign rem_o = rem_q;
  assign par_o = par_q;

endmodule

### rtl/reed_solomon_parity_gf256.sv
// Top level of the systematic Reed-Solomon parity generator over GF(256).
//
// Usage: data codewords enter on the s_axis channel, one byte per request,
// with tlast on the final byte of a block. Parity leaves on the m_axis
// channel, PARITY_BYTES bytes, highest order first, tlast on the final one.
// Throughput: one data byte per cycle while a last byte is not held off;
// one parity byte per cycle while m_axis_tready is high. The first
// parity byte is valid in the cycle after the last data byte is accepted.
// The remainder row of cells updates once per accepted byte; on the last
// byte it is copied into a separate output row and cleared, so the next
// block's data streams in while parity is still being shifted out. The
// last byte of a block is held off (tready low) until the final parity
// byte of the previous block is taken, in the same cycle at the earliest.
// Stall: when m_axis_tready is low the output row holds its place.
// Reset: the remainder clears and no parity is pending.
module reed_solomon_parity_gf256 #(
  parameter int PARITY_BYTES = rsp_pkg::ParityBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_data
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] parity_byte
  output logic       m_axis_tlast_o    // last_parity
);
  import rsp_pkg::*;

  localparam int CntW = $clog2(PARITY_BYTES + 1);

  logic [7:0] rem [0:PARITY_BYTES];
  logic [7:0] par [0:PARITY_BYTES];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_free;
  logic in_acc;
  logic out_acc;
  rsp_ctrl_t ctrl;

  // Zero enters the high end of both rows
  assign rem[PARITY_BYTES] = 8'h00;
  assign par[PARITY_BYTES] = 8'h00;

  // Accept a last byte only when the output row is empty or empties this cycle
  assign out_free        = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready_i);
  assign s_axis_tready_o = !s_axis_tlast_i || out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  // Broadcast control to the cells
  always_comb begin
    ctrl.step  = in_acc;
    ctrl.load  = in_acc && s_axis_tlast_i;
    ctrl.shift = out_acc;
    ctrl.fb    = s_axis_tdata_i ^ rem[0];
  end

  // Row of cells, cell 0 holds the highest-order byte
  for (genvar j = 0; j < PARITY_BYTES; j++) begin : g_cell
    rsp_cell #(
      .COEF(gen_coef(PARITY_BYTES, j + 1))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .rem_up_i(rem[j+1]),
      .par_up_i(par[j+1]),
      .rem_o   (rem[j]),
      .par_o   (par[j])
    );
  end

  // Track how many parity bytes remain in the output row
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.load) begin
      cnt_d = CntW'(PARITY_BYTES);
    end else if (out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Drive the output port from the low end of the output row
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = par[0];
  assign m_axis_tlast_o  = (cnt_q == CntW'(1));

endmodule
